### hdl/arlm_pkg.sv
// ----------------------------------------------------------------------------
// arlm_pkg
// Shared types, codes and constants of the AT response line matcher.
// ----------------------------------------------------------------------------
package arlm_pkg;

    localparam int LINE_LIMIT    = 128;
    localparam int PATTERN_CHARS = 8;

    localparam int FUNC_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int OUTCOME_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;
    localparam int PAT_W     = 64;
    localparam int LEN_W     = 4;
    localparam int TICK_W    = 16;

    localparam int COUNT_W  = $clog2(LINE_LIMIT);
    localparam int RECENT_W = PATTERN_CHARS * BYTE_W;
    localparam int CMP_W    = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

    // result codes
    localparam logic [OUTCOME_W-1:0] OUT_FOUND   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_ERROR   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_TIMEOUT = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    localparam logic [PAT_W-1:0]  RST_PATTERN = 64'd20299;  // "OK"
    localparam logic [LEN_W-1:0]  RST_LENGTH  = 4'd2;
    localparam logic [TICK_W-1:0] RST_TIMEOUT = 16'd3000;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    localparam logic [LEN_W-1:0]    ERROR_CHARS = 4'd5;
    localparam logic [RECENT_W-1:0] ERROR_TEXT  = RECENT_W'(40'h4552524F52);

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(LINE_LIMIT - 1);
    localparam logic [LEN_W-1:0]   K_MAX     = LEN_W'(PATTERN_CHARS);

    typedef struct packed {
        logic                 valid;
        logic [OUTCOME_W-1:0] outcome;
    } t_result;

    // mask of the n lowest characters of the window
    function automatic logic [RECENT_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [RECENT_W-1:0] m;
        m = '0;
        for (int i = 0; i < PATTERN_CHARS; i++) begin
            m[i*BYTE_W +: BYTE_W] = (LEN_W'(i) < n) ? {BYTE_W{1'b1}} : {BYTE_W{1'b0}};
        end
        return m;
    endfunction

    localparam logic [RECENT_W-1:0] ERROR_MASK = byte_mask(ERROR_CHARS);

endpackage

### hdl/arlm_if.sv
// ----------------------------------------------------------------------------
// arlm_if
// Channel interfaces: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface arlm_in_if import arlm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, func, rx_byte, input ready);
    modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface arlm_out_if import arlm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUTCOME_W-1:0] outcome;

    modport source (output valid, outcome, input ready);
    modport sink   (input valid, outcome, output ready);
endinterface

interface arlm_cfg_if import arlm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/at_response_line_matcher.sv
// ----------------------------------------------------------------------------
// at_response_line_matcher
// Matches modem response lines against an expected text, ERROR, or timeout.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  carries items: func (start, received byte, millisecond tick) and
//         rx_byte. A start arms the matcher; bytes build a line, CR is dropped,
//         and LF closes the line. A closed line holding the expected text
//         gives outcome found, else one holding ERROR gives error. Ticks count
//         up to timeout_ticks and give timeout. After a result the matcher is
//         idle until the next start.
//   o_out carries one outcome item per result.
//   i_cfg writes expect_pattern, expect_length and timeout_ticks by index;
//         it is always ready. Write only while idle.
// Timing: one item per cycle while i_in.ready is high. A result appears on
//   o_out the cycle after the item that causes it is taken if no older result
//   waits; the decision is parallel compares against the character window.
// Stall: a two-entry result buffer lets items keep flowing while a result
//   waits; i_in.ready drops only when both entries hold results.
// Reset: registers return to their defaults, the matcher is idle and the
//   result buffer is empty.
// ----------------------------------------------------------------------------
module at_response_line_matcher import arlm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    arlm_in_if.sink     i_in,
    arlm_out_if.source  o_out,
    arlm_cfg_if.sink    i_cfg
);

    logic [PAT_W-1:0]  r_pattern;
    logic [LEN_W-1:0]  r_length;
    logic [TICK_W-1:0] r_timeout;

    logic    full;
    logic    in_accept;
    t_result result;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !full;
    assign in_accept   = i_in.valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= RST_PATTERN;
            r_length  <= RST_LENGTH;
            r_timeout <= RST_TIMEOUT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PATTERN: r_pattern <= i_cfg.data[PAT_W-1:0];
                REG_LENGTH:  r_length  <= i_cfg.data[LEN_W-1:0];
                REG_TIMEOUT: r_timeout <= i_cfg.data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    arlm_match u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_func    (i_in.func),
        .i_rx_byte (i_in.rx_byte),
        .i_pattern (r_pattern),
        .i_length  (r_length),
        .i_timeout (r_timeout),
        .o_result  (result)
    );

    arlm_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .o_full   (full),
        .o_out    (o_out)
    );

endmodule

### hdl/arlm_match.sv
// ----------------------------------------------------------------------------
// arlm_match
// Line state and matching: one accepted item is decoded and applied per cycle.
// ----------------------------------------------------------------------------
module arlm_match import arlm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    input  logic [PAT_W-1:0]    i_pattern,
    input  logic [LEN_W-1:0]    i_length,
    input  logic [TICK_W-1:0]   i_timeout,
    output t_result             o_result
);

    logic                r_armed,   n_armed;
    logic [COUNT_W-1:0]  r_count,   n_count;
    logic [RECENT_W-1:0] r_recent,  n_recent;
    logic                r_exp,     n_exp;
    logic                r_err,     n_err;
    logic [TICK_W-1:0]   r_elapsed, n_elapsed;

    logic [LEN_W-1:0]    k;
    logic [COUNT_W-1:0]  cnt_inc;
    logic [RECENT_W-1:0] rec_shift;
    logic                exp_hit;
    logic                err_hit;
    logic [TICK_W-1:0]   el_inc;

    assign k         = (i_length > K_MAX) ? K_MAX : i_length;
    assign cnt_inc   = r_count + COUNT_W'(1);
    assign rec_shift = {r_recent[RECENT_W-BYTE_W-1:0], i_rx_byte};
    assign exp_hit   = (k != '0) && (CMP_W'(cnt_inc) >= CMP_W'(k))
                       && (((rec_shift ^ i_pattern[RECENT_W-1:0]) & byte_mask(k)) == '0);
    assign err_hit   = (CMP_W'(cnt_inc) >= CMP_W'(ERROR_CHARS))
                       && (((rec_shift ^ ERROR_TEXT) & ERROR_MASK) == '0);
    assign el_inc    = (r_elapsed != '1) ? r_elapsed + TICK_W'(1) : r_elapsed;

    always_comb begin
        n_armed          = r_armed;
        n_count          = r_count;
        n_recent         = r_recent;
        n_exp            = r_exp;
        n_err            = r_err;
        n_elapsed        = r_elapsed;
        o_result.valid   = 1'b0;
        o_result.outcome = OUT_FOUND;
        if (i_accept) begin
            unique case (i_func)
                FUNC_START: begin
                    n_armed   = 1'b1;
                    n_elapsed = '0;
                    n_count   = '0;
                    n_recent  = '0;
                    n_exp     = 1'b0;
                    n_err     = 1'b0;
                end
                FUNC_TICK: begin
                    if (r_armed) begin
                        n_elapsed = el_inc;
                        if (el_inc >= i_timeout) begin
                            n_armed          = 1'b0;
                            o_result.valid   = 1'b1;
                            o_result.outcome = OUT_TIMEOUT;
                        end
                    end
                end
                FUNC_BYTE: begin
                    if (r_armed) begin
                        if (i_rx_byte == CHAR_LF) begin
                            if (r_count != '0 && r_exp) begin
                                n_armed          = 1'b0;
                                o_result.valid   = 1'b1;
                                o_result.outcome = OUT_FOUND;
                            end else if (r_count != '0 && r_err) begin
                                n_armed          = 1'b0;
                                o_result.valid   = 1'b1;
                                o_result.outcome = OUT_ERROR;
                            end else begin
                                n_count  = '0;
                                n_recent = '0;
                                n_exp    = 1'b0;
                                n_err    = 1'b0;
                            end
                        end else if (i_rx_byte != CHAR_CR && r_count < COUNT_MAX) begin
                            n_count  = cnt_inc;
                            n_recent = rec_shift;
                            n_exp    = r_exp | exp_hit;
                            n_err    = r_err | err_hit;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_count   <= '0;
            r_recent  <= '0;
            r_exp     <= 1'b0;
            r_err     <= 1'b0;
            r_elapsed <= '0;
        end else begin
            r_armed   <= n_armed;
            r_count   <= n_count;
            r_recent  <= n_recent;
            r_exp     <= n_exp;
            r_err     <= n_err;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

### hdl/arlm_skid.sv
// ----------------------------------------------------------------------------
// arlm_skid
// Two-entry result buffer between the matcher and the output channel.
// ----------------------------------------------------------------------------
module arlm_skid import arlm_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_result        i_result,
    output logic           o_full,
    arlm_out_if.source     o_out
);

    logic                 r_v0, n_v0;
    logic                 r_v1, n_v1;
    logic [OUTCOME_W-1:0] r_q0, n_q0;
    logic [OUTCOME_W-1:0] r_q1, n_q1;
    logic                 pop;

    assign pop           = r_v0 && o_out.ready;
    assign o_out.valid   = r_v0;
    assign o_out.outcome = r_q0;
    assign o_full        = r_v1;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (pop) begin
            n_v0 = r_v1;
            n_q0 = r_q1;
            n_v1 = 1'b0;
        end
        if (i_result.valid) begin
            if (!n_v0) begin
                n_v0 = 1'b1;
                n_q0 = i_result.outcome;
            end else begin
                n_v1 = 1'b1;
                n_q1 = i_result.outcome;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the AT response line matcher. Items, register
// writes and results go through valid/ready channels; items see random gaps
// and results random stalls. An outcome board tracks the line, match flags
// and tick count and queues the outcome, if any, each accepted item should give.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arlm_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4;
    localparam int TICK_PCT     = 8;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;
    localparam logic [TICK_W-1:0] LONG_TIMEOUT = 16'hFFFF;
    localparam logic [TICK_W-1:0] RUN_TIMEOUT  = 16'd100;

    typedef enum int {INS_NONE, INS_PATTERN, INS_ERROR, INS_PARTIAL} insert_e;

    // tracks matcher state and the outcomes still owed by the block
    class outcome_board;
        logic [PAT_W-1:0]     pattern;
        logic [LEN_W-1:0]     pat_len;
        logic [TICK_W-1:0]    timeout;
        bit                   armed;
        int unsigned          line_cnt;
        logic [RECENT_W-1:0]  window;
        bit                   pat_hit;
        bit                   err_hit;
        logic [TICK_W-1:0]    elapsed;
        logic [OUTCOME_W-1:0] pending[$];
        int                   errors;

        function new();
            pattern = RST_PATTERN;
            pat_len = RST_LENGTH;
            timeout = RST_TIMEOUT;
            armed   = 1'b0;
            elapsed = '0;
            errors  = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_cnt = 0;
            window   = '0;
            pat_hit  = 1'b0;
            err_hit  = 1'b0;
        endfunction

        function logic [RECENT_W-1:0] low_mask(int unsigned n);
            logic [RECENT_W-1:0] m;
            m = '0;
            for (int i = 0; i < PATTERN_CHARS; i++) begin
                if (i < n) m[i*BYTE_W +: BYTE_W] = '1;
            end
            return m;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_PATTERN: pattern = val[PAT_W-1:0];
                REG_LENGTH:  pat_len = val[LEN_W-1:0];
                REG_TIMEOUT: timeout = val[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        // returns 1 when the matcher acts on the item
        function bit note_item(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b);
            int unsigned k;
            if (f == FUNC_START) begin
                armed   = 1'b1;
                elapsed = '0;
                clear_line();
                return 1'b1;
            end
            if (!armed || f == FUNC_UNUSED) return 1'b0;
            if (f == FUNC_TICK) begin
                if (elapsed != '1) elapsed++;
                if (elapsed >= timeout) begin
                    armed = 1'b0;
                    pending.push_back(OUT_TIMEOUT);
                end
                return 1'b1;
            end
            if (b == CHAR_LF) begin
                if (line_cnt > 0 && pat_hit) begin
                    armed = 1'b0;
                    pending.push_back(OUT_FOUND);
                    return 1'b1;
                end
                if (line_cnt > 0 && err_hit) begin
                    armed = 1'b0;
                    pending.push_back(OUT_ERROR);
                    return 1'b1;
                end
                clear_line();
                return 1'b1;
            end
            if (b == CHAR_CR || line_cnt >= LINE_LIMIT - 1) return 1'b1;
            line_cnt++;
            window = {window[RECENT_W-BYTE_W-1:0], b};
            k = (pat_len > PATTERN_CHARS) ? PATTERN_CHARS : pat_len;
            if (k > 0 && line_cnt >= k && ((window ^ pattern) & low_mask(k)) == '0)
                pat_hit = 1'b1;
            if (line_cnt >= ERROR_CHARS && ((window ^ ERROR_TEXT) & ERROR_MASK) == '0)
                err_hit = 1'b1;
            return 1'b1;
        endfunction

        function void check_outcome(logic [OUTCOME_W-1:0] got);
            logic [OUTCOME_W-1:0] want;
            if (pending.size() == 0) begin
                $error("outcome: expected none, actual %0d", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $error("outcome: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    arlm_in_if  in_ch();
    arlm_out_if out_ch();
    arlm_cfg_if cfg_ch();

    at_response_line_matcher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    outcome_board sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int live_items     = 0;
    int cycle_cnt      = 0;
    bit hold_req       = 1'b0;

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // result receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_outcome(out_ch.outcome);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.func    <= f;
        in_ch.rx_byte <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        void'(sb.note_item(f, b));
        live_items++;
    endtask

    // a character, sometimes preceded by a tick
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < TICK_PCT) send_item(FUNC_TICK, BYTE_W'($urandom));
        send_item(FUNC_BYTE, b);
    endtask

    task automatic program_regs(input logic [PAT_W-1:0] pat, input logic [LEN_W-1:0] len,
                                input logic [TICK_W-1:0] tmo);
        logic [CFG_IDX_W-1:0] idx[3];
        logic [CFG_DAT_W-1:0] val[3];
        idx = '{REG_PATTERN, REG_LENGTH, REG_TIMEOUT};
        val[0] = pat;
        val[1] = {$urandom, $urandom};
        val[1][LEN_W-1:0] = len;
        val[2] = {$urandom, $urandom};
        val[2][TICK_W-1:0] = tmo;
        for (int i = 0; i < 3; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one line of filler with the expected text, ERROR, a broken prefix or nothing inside
    task automatic send_line();
        int      n;
        int      at;
        int      k;
        insert_e kind;
        int      r;
        if ($urandom_range(99) < 10) n = $urandom_range(LINE_LIMIT - 10, LINE_LIMIT + 12);
        else n = $urandom_range(0, 10);
        at   = $urandom_range(n);
        kind = insert_e'($urandom_range(3));
        k    = (sb.pat_len > PATTERN_CHARS) ? PATTERN_CHARS : sb.pat_len;
        for (int i = 0; i <= n; i++) begin
            if (i == at) begin
                case (kind)
                    INS_PATTERN: for (int j = k - 1; j >= 0; j--)
                        send_byte(sb.pattern[j*BYTE_W +: BYTE_W]);
                    INS_ERROR: for (int j = ERROR_CHARS - 1; j >= 0; j--)
                        send_byte(ERROR_TEXT[j*BYTE_W +: BYTE_W]);
                    INS_PARTIAL: for (int j = k - 1; j > 0; j--)
                        send_byte(sb.pattern[j*BYTE_W +: BYTE_W]);
                    default: ;
                endcase
            end
            if (i < n) begin
                r = $urandom_range(99);
                if (r < 8) send_byte(CHAR_CR);
                else if (r < 11) send_byte(8'h00);
                else send_byte(BYTE_W'($urandom));
            end
        end
        // unterminated lines now and then
        if ($urandom_range(99) < 90) send_item(FUNC_BYTE, CHAR_LF);
    endtask

    task automatic run_session();
        if ($urandom_range(99) < 85) send_item(FUNC_START, BYTE_W'($urandom));
        else send_item(FUNC_W'($urandom_range(3)), BYTE_W'($urandom));
        repeat ($urandom_range(1, 4)) send_line();
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 8)) send_item(FUNC_TICK, BYTE_W'($urandom));
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [PAT_W-1:0] pat,
                             input logic [LEN_W-1:0] len, input logic [TICK_W-1:0] tmo,
                             input int target);
        wait_drained();
        program_regs(pat, len, tmo);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        live_items     = 0;
        while (live_items < target) run_session();
        in_ch.valid <= 1'b0;
    endtask

    function automatic logic [PAT_W-1:0] clean_pattern();
        logic [PAT_W-1:0] p;
        p = {$urandom, $urandom};
        // keep CR and LF out so the text survives inside a line
        for (int i = 0; i < PATTERN_CHARS; i++) begin
            if (p[i*BYTE_W +: BYTE_W] == CHAR_CR || p[i*BYTE_W +: BYTE_W] == CHAR_LF)
                p[i*BYTE_W +: BYTE_W] ^= 8'h40;
        end
        return p;
    endfunction

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.func    <= FUNC_START;
        in_ch.rx_byte <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_PATTERN;
        cfg_ch.data   <= '0;
        i_rst_n       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: idle items ignored, then OK with CR before LF
        send_item(FUNC_BYTE, 8'hFF);
        send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_UNUSED, 8'hFF);
        send_item(FUNC_START, 8'h00);
        send_item(FUNC_BYTE, RST_PATTERN[15:8]);
        send_item(FUNC_BYTE, RST_PATTERN[7:0]);
        send_item(FUNC_BYTE, CHAR_CR);
        send_item(FUNC_BYTE, CHAR_LF);
        // empty line, a line of one NUL, restart while armed, then ERROR
        send_item(FUNC_START, 8'hFF);
        send_item(FUNC_BYTE, CHAR_LF);
        send_item(FUNC_BYTE, 8'h00);
        send_item(FUNC_BYTE, CHAR_LF);
        send_item(FUNC_START, 8'h00);
        send_item(FUNC_UNUSED, 8'h00);
        for (int j = ERROR_CHARS - 1; j >= 0; j--)
            send_item(FUNC_BYTE, ERROR_TEXT[j*BYTE_W +: BYTE_W]);
        send_item(FUNC_BYTE, CHAR_LF);
        in_ch.valid <= 1'b0;
        // zero timeout: first tick ends it
        wait_drained();
        program_regs(RST_PATTERN, RST_LENGTH, '0);
        send_item(FUNC_START, 8'h00);
        send_item(FUNC_TICK, 8'hFF);
        in_ch.valid <= 1'b0;

        run_phase(0, 0, clean_pattern(), LEN_W'($urandom_range(1, PATTERN_CHARS)),
                  TICK_W'($urandom_range(20, 80)), 250);
        run_phase(62, 0, '0, 4'd3, 16'd1, 200);
        run_phase(0, 62, '1, 4'd8, LONG_TIMEOUT, 200);
        run_phase(22, 22, {$urandom, $urandom}, 4'd15, 16'd30, 250);
        run_phase(0, 0, clean_pattern(), 4'd0, 16'd40, 250);

        // receiver holds off while results keep coming: input must back up
        wait_drained();
        program_regs(RST_PATTERN, RST_LENGTH, 16'd100);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        repeat (30) begin
            send_item(FUNC_START, BYTE_W'($urandom));
            send_item(FUNC_BYTE, RST_PATTERN[15:8]);
            send_item(FUNC_BYTE, RST_PATTERN[7:0]);
            send_item(FUNC_BYTE, CHAR_LF);
        end
        in_ch.valid <= 1'b0;

        // timeout reached by back-to-back ticks; extra ticks are ignored
        wait_drained();
        program_regs(clean_pattern(), 4'd0, RUN_TIMEOUT);
        recv_stall_pct = 22;
        send_item(FUNC_START, 8'h00);
        repeat (int'(RUN_TIMEOUT) + 2) send_item(FUNC_TICK, BYTE_W'($urandom));
        in_ch.valid <= 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

### sim.f
hdl/arlm_pkg.sv
hdl/arlm_if.sv
hdl/arlm_match.sv
hdl/arlm_skid.sv
hdl/at_response_line_matcher.sv
dv/tb.sv
